// ===== rtl/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// Path point decimator package
// Shared payload types, register indexes and widths.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int unsigned MaxPoints = 65536;
  localparam int unsigned CountW    = $clog2(MaxPoints + 1);
  localparam int unsigned ArcW      = 40;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] RegMinSpacing = 2'd0;
  localparam logic [CfgIdxW-1:0] RegShiftX     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegShiftY     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegTurnThresh = 2'd3;

  typedef struct packed {
    logic signed [31:0] pos_x_mm;
    logic signed [31:0] pos_y_mm;
    logic signed [15:0] heading_angle;
    logic               has_heading;
    logic               start_new_path;
  } in_item_t;

  typedef struct packed {
    logic               kept;
    logic [15:0]        point_index;
    logic signed [31:0] out_x_mm;
    logic signed [31:0] out_y_mm;
    logic [ArcW-1:0]    arc_length_mm;
    logic               course_mark;
  } out_item_t;

endpackage

// ===== rtl/ppd_isqrt.sv =====
// ----------------------------------------------------------------------------
// Path point decimator square root unit
// Squares two 33-bit magnitudes bit-serially and then takes the integer
// square root of the 66-bit sum, one root bit per cycle.
// ----------------------------------------------------------------------------
module ppd_isqrt
  import ppd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] ax_i,
  input  logic [32:0] ay_i,
  output logic        done_o,
  output logic [32:0] root_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSq   = 2'd1;
  localparam logic [1:0] StRoot = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] mx_q, mx_d, my_q, my_d;
  logic [32:0] ax_q, ax_d, ay_q, ay_d;
  logic [65:0] acc_q, acc_d;
  logic [34:0] rem_q, rem_d;
  logic [32:0] root_q, root_d;
  logic        done_q, done_d;
  logic [34:0] rem_sh, trial;

  // Each squaring step adds one shifted partial product of each square.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mx_d    = mx_q;
    my_d    = my_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    done_d  = 1'b0;
    rem_sh  = {rem_q[32:0], acc_q[65:64]};
    trial   = {root_q[32:0], 2'b01};
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StSq;
          cnt_d   = 6'd0;
          mx_d    = ax_i;
          my_d    = ay_i;
          ax_d    = ax_i;
          ay_d    = ay_i;
          acc_d   = '0;
        end
      end
      StSq: begin
        acc_d = acc_q + (mx_q[0] ? {33'd0, ax_q} : 66'd0)
                      + (my_q[0] ? {33'd0, ay_q} : 66'd0);
        mx_d  = mx_q >> 1;
        my_d  = my_q >> 1;
        ax_d  = ax_q;
        ay_d  = ay_q;
        // Partial products are accumulated MSB-aligned by rotating the sum.
        acc_d = {acc_d[0], acc_d[65:1]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          // Undo the remaining rotation: 33 right rotates of 66 bits.
          acc_d = {acc_d[32:0], acc_d[65:33]};
          state_d = StRoot;
          cnt_d   = 6'd0;
          rem_d   = '0;
          root_d  = '0;
        end
      end
      StRoot: begin
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[31:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[31:0], 1'b0};
        end
        acc_d = {acc_q[63:0], 2'b00};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          state_d = StIdle;
          done_d  = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q   <= mx_d;
    my_q   <= my_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/path_point_decimator.sv =====
// ----------------------------------------------------------------------------
// Path point decimator
// Keeps recorded path points that lie at least a minimum spacing apart.
// ----------------------------------------------------------------------------
// Usage: points enter on the input channel (in_valid_i / in_stall_o) and one
// result per point leaves on the output channel (out_valid_o / out_stall_i).
// A transfer happens on a rising edge with valid high and stall low.
// Registers are written through cfg_valid_i / cfg_ready_o with an index and
// 16 bits of data; the user writes them only while the block is idle, which the block itself does not enforce.
// The first point of a path and points past the path limit skip the distance
// unit and are loaded into the output register from the distance state; any
// other point passes through the distance unit: it is started, squares both
// offsets one multiplier bit a cycle, forms one square root bit a cycle, and
// then the result is loaded into the output register.
// One point is processed at a time; the next is taken once the result has
// moved to the output register.
// Reset clears the path state and loads the register defaults. When the
// receiver stalls, the result holds and at most one further point is taken
// up to that output register.
// ----------------------------------------------------------------------------
module path_point_decimator
  import ppd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDist = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [15:0]        min_sp_q;
  logic signed [15:0] shx_q, shy_q;
  logic [14:0]        thr_q;

  logic [CountW-1:0]  cnt_q;
  logic signed [31:0] lx_q, ly_q;
  logic [ArcW-1:0]    len_q;
  logic signed [15:0] ph_q;
  logic               phv_q;

  logic [1:0]         state_q;
  in_item_t           it_q;
  logic signed [31:0] nx_q, ny_q;
  logic               first_q, full_q;
  logic               ovalid_q;
  out_item_t          odata_q;

  logic               sq_start, sq_done;
  logic               sq_busy_q;
  logic [32:0]        sq_root;
  logic signed [32:0] ddx, ddy;
  logic [32:0]        adx, ady;

  logic signed [32:0] sumx, sumy;
  logic signed [31:0] satx, saty;

  logic               in_acc, out_acc;
  logic               load_dist, load_done;

  // Result forming.
  logic               keep;
  logic [32:0]        seg_len;
  logic [ArcW:0]      len_sum;
  logic [ArcW-1:0]    len_new;
  logic signed [15:0] href, hdiff;
  logic [15:0]        hmag;
  logic               ready_res;

  // Held result when the distance finishes while the output is still full.
  logic               odata_keep_q;
  logic [ArcW-1:0]    len_hold_q;
  out_item_t          res_hold_q, res_now;
  logic [CountW-1:0]  cnt_after;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sp_q <= 16'd100;
      shx_q    <= '0;
      shy_q    <= '0;
      thr_q    <= 15'd5461;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMinSpacing: min_sp_q <= cfg_data_i;
        RegShiftX:     shx_q    <= cfg_data_i;
        RegShiftY:     shy_q    <= cfg_data_i;
        RegTurnThresh: thr_q    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign sumx = 33'(in_data_i.pos_x_mm) + 33'(shx_q);
  assign sumy = 33'(in_data_i.pos_y_mm) + 33'(shy_q);
  assign satx = (sumx[32] != sumx[31]) ? {sumx[32], {31{~sumx[32]}}} : sumx[31:0];
  assign saty = (sumy[32] != sumy[31]) ? {sumy[32], {31{~sumy[32]}}} : sumy[31:0];

  assign ddx = 33'(nx_q) - 33'(lx_q);
  assign ddy = 33'(ny_q) - 33'(ly_q);
  assign adx = ddx[32] ? 33'(-ddx) : ddx;
  assign ady = ddy[32] ? 33'(-ddy) : ddy;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign out_acc    = ovalid_q && !out_stall_i;
  assign sq_start   = (state_q == StDist) && !first_q && !full_q && !sq_busy_q;

  ppd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .ax_i    (adx),
    .ay_i    (ady),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign ready_res = first_q || full_q || sq_done;
  assign seg_len   = (first_q || full_q) ? 33'd0 : sq_root;
  assign keep      = !full_q && (first_q || (seg_len >= {17'd0, min_sp_q}));
  assign len_sum   = {1'b0, len_q} + {8'd0, seg_len};
  assign len_new   = len_sum[ArcW] ? {ArcW{1'b1}} : len_sum[ArcW-1:0];
  assign href      = phv_q ? ph_q : it_q.heading_angle;
  assign hdiff     = it_q.heading_angle - href;
  assign hmag      = hdiff[15] ? 16'(-hdiff) : hdiff;

  assign load_dist = (state_q == StDist) && ready_res && (!ovalid_q || out_acc);
  assign load_done = (state_q == StDone) && (!ovalid_q || out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      sq_busy_q <= 1'b0;
      ovalid_q  <= 1'b0;
      cnt_q     <= '0;
      lx_q      <= '0;
      ly_q      <= '0;
      len_q     <= '0;
      ph_q      <= '0;
      phv_q     <= 1'b0;
    end else begin
      if (load_dist || load_done) begin
        ovalid_q <= 1'b1;
      end else if (out_acc) begin
        ovalid_q <= 1'b0;
      end
      if (sq_start) begin
        sq_busy_q <= 1'b1;
      end else if (load_dist || load_done) begin
        sq_busy_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (in_data_i.start_new_path) begin
              cnt_q <= '0;
              lx_q  <= '0;
              ly_q  <= '0;
              len_q <= '0;
              ph_q  <= '0;
              phv_q <= 1'b0;
            end
            state_q <= StDist;
          end
        end
        StDist: begin
          if (load_dist) begin
            state_q <= StIdle;
            if (keep) begin
              if (!first_q) len_q <= len_new;
              lx_q  <= nx_q;
              ly_q  <= ny_q;
              cnt_q <= cnt_q + 1'b1;
              if (it_q.has_heading) begin
                ph_q  <= it_q.heading_angle;
                phv_q <= 1'b1;
              end
            end
          end else if (sq_done) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (load_done) begin
            state_q <= StIdle;
            if (odata_keep_q) begin
              len_q <= len_hold_q;
              lx_q  <= nx_q;
              ly_q  <= ny_q;
              cnt_q <= cnt_q + 1'b1;
              if (it_q.has_heading) begin
                ph_q  <= it_q.heading_angle;
                phv_q <= 1'b1;
              end
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign cnt_after = (state_q == StIdle && in_acc && in_data_i.start_new_path)
                     ? '0 : cnt_q;

  always_comb begin
    res_now = '0;
    if (keep) begin
      res_now.kept          = 1'b1;
      res_now.point_index   = (cnt_q > CountW'(16'hFFFF)) ? 16'hFFFF : cnt_q[15:0];
      res_now.out_x_mm      = nx_q;
      res_now.out_y_mm      = ny_q;
      res_now.arc_length_mm = first_q ? len_q : len_new;
      res_now.course_mark   = it_q.has_heading && (hmag > {1'b0, thr_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      it_q    <= in_data_i;
      nx_q    <= satx;
      ny_q    <= saty;
      first_q <= (cnt_after == '0);
      full_q  <= (cnt_after >= CountW'(MaxPoints));
    end
    if (state_q == StDist && sq_done) begin
      res_hold_q   <= res_now;
      odata_keep_q <= keep;
      len_hold_q   <= len_new;
    end
    if (load_dist) begin
      odata_q <= res_now;
    end else if (load_done) begin
      odata_q <= res_hold_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Path point decimator testbench
// Drives recorded path points through the decimator under several register
// settings and idling patterns. A table of directed points covers reset
// behavior, spacing, new paths, extreme positions and heading wrap; two
// points cover saturating shifts. Random walks follow. Results are checked
// against the table or an in-bench model of spacing, arc length and marks.
// ----------------------------------------------------------------------------
module tb;
  import ppd_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned SettleCycles = 120;

  typedef struct {
    in_item_t  point;
    bit        typed;
    out_item_t want;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic [15:0]        min_spacing;
  logic signed [15:0] shift_x;
  logic signed [15:0] shift_y;
  logic [14:0]        turn_limit;
  int unsigned        kept_total;
  logic signed [31:0] last_x;
  logic signed [31:0] last_y;
  logic [ArcW-1:0]    path_len;
  logic signed [15:0] last_heading;
  bit                 heading_seen;

  out_item_t   pending_points[$];
  int unsigned mismatch_count = 0;
  int unsigned points_sent = 0;
  int unsigned points_kept = 0;
  int unsigned marks_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic signed [31:0] walk_x = 0;
  logic signed [31:0] walk_y = 0;
  logic signed [15:0] walk_h = 0;

  path_point_decimator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [39:0] floor_sqrt(logic [65:0] v);
    logic [67:0] rem;
    logic [67:0] root;
    logic [67:0] trial;
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 68'(v[2*i +: 2]);
      trial = (root << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 68'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[39:0];
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a, logic signed [15:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic out_item_t decimate_point(in_item_t p);
    out_item_t          r;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    longint             dx;
    longint             dy;
    logic [65:0]        ax;
    logic [65:0]        ay;
    logic [39:0]        seg_len;
    logic [40:0]        sum;
    logic signed [15:0] base;
    logic signed [15:0] diff;
    int                 mag;
    bit                 keep;
    r = '0;
    seg_len = '0;
    if (p.start_new_path) begin
      kept_total = 0;
      last_x = 0;
      last_y = 0;
      path_len = '0;
      last_heading = 0;
      heading_seen = 0;
    end
    nx = sat_add(p.pos_x_mm, shift_x);
    ny = sat_add(p.pos_y_mm, shift_y);
    if (kept_total >= MaxPoints) begin
      keep = 0;
    end else if (kept_total == 0) begin
      keep = 1;
    end else begin
      dx = longint'(nx) - longint'(last_x);
      dy = longint'(ny) - longint'(last_y);
      ax = 66'(dx < 0 ? -dx : dx);
      ay = 66'(dy < 0 ? -dy : dy);
      seg_len = floor_sqrt(ax * ax + ay * ay);
      keep = seg_len >= 40'(min_spacing);
    end
    if (!keep) return r;
    if (kept_total > 0) begin
      sum = 41'(path_len) + 41'(seg_len);
      path_len = sum[40] ? {ArcW{1'b1}} : sum[39:0];
    end
    r.kept = 1'b1;
    r.point_index = kept_total > 65535 ? 16'hffff : 16'(kept_total);
    r.out_x_mm = nx;
    r.out_y_mm = ny;
    r.arc_length_mm = path_len;
    if (p.has_heading) begin
      base = heading_seen ? last_heading : p.heading_angle;
      diff = p.heading_angle - base;
      mag = diff < 0 ? -int'(diff) : int'(diff);
      r.course_mark = mag > int'(turn_limit);
      last_heading = p.heading_angle;
      heading_seen = 1;
    end
    last_x = nx;
    last_y = ny;
    kept_total++;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (in_valid && !in_stall) idle_cycles <= 0;
    else if (out_valid && !out_stall) idle_cycles <= 0;
    else if (cfg_valid && cfg_ready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected result, kept", out_data.kept, 0);
      end else begin
        want = pending_points.pop_front();
        if (out_data.kept !== want.kept)
          report_mismatch("kept", out_data.kept, want.kept);
        if (out_data.point_index !== want.point_index)
          report_mismatch("point_index", out_data.point_index, want.point_index);
        if (out_data.out_x_mm !== want.out_x_mm)
          report_mismatch("out_x_mm", out_data.out_x_mm, want.out_x_mm);
        if (out_data.out_y_mm !== want.out_y_mm)
          report_mismatch("out_y_mm", out_data.out_y_mm, want.out_y_mm);
        if (out_data.arc_length_mm !== want.arc_length_mm)
          report_mismatch("arc_length_mm", out_data.arc_length_mm, want.arc_length_mm);
        if (out_data.course_mark !== want.course_mark)
          report_mismatch("course_mark", out_data.course_mark, want.course_mark);
        points_kept += want.kept;
        marks_seen += want.course_mark;
      end
    end
  end

  task automatic send_point(in_item_t p, bit typed, out_item_t want);
    out_item_t got;
    in_data <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    got = decimate_point(p);
    pending_points.insert(pending_points.size(), typed ? want : got);
    points_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegMinSpacing: min_spacing = val;
      RegShiftX:     shift_x = val;
      RegShiftY:     shift_y = val;
      RegTurnThresh: turn_limit = val[14:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t make_point(bit start);
    in_item_t p;
    int unsigned reach;
    reach = 2 * int'(min_spacing) + 16;
    if ($urandom_range(99) < 6) begin
      walk_x = $urandom;
      walk_y = $urandom;
    end else if ($urandom_range(99) < 4) begin
      walk_x = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      walk_y = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    end else begin
      walk_x = walk_x + $signed($urandom_range(2 * reach)) - $signed(reach);
      walk_y = walk_y + $signed($urandom_range(2 * reach)) - $signed(reach);
    end
    if ($urandom_range(1)) walk_h = walk_h + $signed(16'($urandom_range(8000))) - 16'sd4000;
    else walk_h = 16'($urandom);
    p.pos_x_mm = walk_x;
    p.pos_y_mm = walk_y;
    p.heading_angle = walk_h;
    p.has_heading = $urandom_range(99) < 70;
    p.start_new_path = start;
    return p;
  endfunction

  initial begin
    step_row_t rows[$];
    step_row_t row;
    out_item_t none;
    logic [15:0] cfg_sets[4][4];
    none = '0;
    min_spacing = 16'd100;
    shift_x = 0;
    shift_y = 0;
    turn_limit = 15'd5461;
    kept_total = 0;
    last_x = 0;
    last_y = 0;
    path_len = '0;
    last_heading = 0;
    heading_seen = 0;

    row.point = '{32'sd1000, -32'sd2000, 16'sd0, 1'b1, 1'b0};
    row.typed = 1;
    row.want = '{1'b1, 16'd0, 32'sd1000, -32'sd2000, 40'd0, 1'b0};
    rows.insert(rows.size(), row);
    row.point = '{32'sd1000, -32'sd1950, 16'sd100, 1'b0, 1'b0};
    row.want = none;
    rows.insert(rows.size(), row);
    row.point = '{32'sd1000, -32'sd1900, 16'sd16384, 1'b1, 1'b0};
    row.want = '{1'b1, 16'd1, 32'sd1000, -32'sd1900, 40'd100, 1'b1};
    rows.insert(rows.size(), row);
    row.point = '{32'sd1060, -32'sd1820, 16'sd16000, 1'b1, 1'b0};
    row.want = '{1'b1, 16'd2, 32'sd1060, -32'sd1820, 40'd200, 1'b0};
    rows.insert(rows.size(), row);
    row.point = '{32'sd1060, -32'sd1720, -16'sd20000, 1'b0, 1'b0};
    row.want = '{1'b1, 16'd3, 32'sd1060, -32'sd1720, 40'd300, 1'b0};
    rows.insert(rows.size(), row);
    row.point = '{32'sh7fffffff, 32'sh80000000, 16'sh8000, 1'b1, 1'b1};
    row.want = '{1'b1, 16'd0, 32'sh7fffffff, 32'sh80000000, 40'd0, 1'b0};
    rows.insert(rows.size(), row);
    row.typed = 0;
    row.point = '{32'sh80000000, 32'sh7fffffff, 16'sh0000, 1'b1, 1'b0};
    rows.insert(rows.size(), row);
    row.point = '{32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 1'b1, 1'b0};
    rows.insert(rows.size(), row);
    row.point = '{32'sh80000000, 32'sh80000000, 16'sh8000, 1'b1, 1'b0};
    rows.insert(rows.size(), row);
    row.point = '{32'sd5, 32'sd7, 16'sd30000, 1'b1, 1'b1};
    rows.insert(rows.size(), row);
    row.point = '{32'sd65, 32'sd87, -16'sd30000, 1'b1, 1'b0};
    rows.insert(rows.size(), row);
    row.point = '{32'sd124, 32'sd167, -16'sd30000, 1'b1, 1'b0};
    rows.insert(rows.size(), row);
    row.point = '{-32'sd1, -32'sd1, 16'sd5461, 1'b1, 1'b1};
    rows.insert(rows.size(), row);
    row.point = '{-32'sd101, -32'sd1, 16'sd10922, 1'b1, 1'b0};
    rows.insert(rows.size(), row);
    row.point = '{-32'sd201, -32'sd1, 16'sd16384, 1'b1, 1'b0};
    rows.insert(rows.size(), row);

    cfg_sets[0] = '{16'd0, 16'h8000, 16'h7fff, 16'd0};
    cfg_sets[1] = '{16'hffff, 16'h7fff, 16'h8000, 16'h7fff};
    cfg_sets[2] = '{16'd300, 16'd1234, 16'hffb3, 16'd8000};
    cfg_sets[3] = '{16'd1, 16'd0, 16'd0, 16'd16384};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_point(rows[i].point, rows[i].typed, rows[i].want);
    drain();

    write_reg(RegShiftX, 16'h7fff);
    write_reg(RegShiftY, 16'h8000);
    send_point('{32'sh7fffff00, 32'sh80000100, 16'sd0, 1'b1, 1'b1}, 1,
               '{1'b1, 16'd0, 32'sh7fffffff, 32'sh80000000, 40'd0, 1'b0});
    send_point('{32'sh7ffff000, 32'sh80001000, 16'sd0, 1'b1, 1'b0}, 0, none);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegMinSpacing, cfg_sets[ph][0]);
      write_reg(RegShiftX, cfg_sets[ph][1]);
      write_reg(RegShiftY, cfg_sets[ph][2]);
      write_reg(RegTurnThresh, cfg_sets[ph][3]);
      for (int k = 0; k < 200; k++) begin
        case ((ph + k / 50) % 4)
          0: begin send_idle_pct = 0; stall_pct = 0; end
          1: begin send_idle_pct = 46; stall_pct = 0; end
          2: begin send_idle_pct = 0; stall_pct = 46; end
          default: begin send_idle_pct = 15; stall_pct = 15; end
        endcase
        if (k == 100) begin
          drain();
        end
        send_point(make_point(k == 0 || $urandom_range(99) < 4), 0, none);
      end
      drain();
    end

    stall_pct = 0;
    drain();
    $display("Sent %0d path points over 4 register settings and 4 idling patterns.",
             points_sent);
    $display("Checked %0d kept points and %0d course marks; %0d mismatches.",
             points_kept, marks_seen, mismatch_count);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
